// ===== hdl/llma_pkg.sv =====
// ----------------------------------------------------------------------------
// llma_pkg
// Shared constants, types and the brightness scaling for the light-level
// moving average.
// ----------------------------------------------------------------------------
package llma_pkg;

  localparam int WINDOW     = 64;
  localparam int SLOT_W     = $clog2(WINDOW);
  localparam int SAMPLE_W   = 12;
  localparam int PCT_W      = 7;
  localparam int SUM_W      = SAMPLE_W + SLOT_W;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE  = 12'd4095;
  localparam logic [SAMPLE_W-1:0] DARK_LIMIT  = 12'd5;
  localparam logic [PCT_W-1:0]    PERCENT_MAX = 7'd100;

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;
  typedef logic [PCT_W-1:0]    pct_t;

  typedef struct packed {
    logic    en;
    slot_t   slot;
    sample_t data;
  } ring_wr_t;

  // 100 - floor(mean * 100 / 4095), clamped at both ends.
  // floor(p / 4095) = (p + (p >> 12) + 1) >> 12 holds for p < 4095 * 4096.
  function automatic pct_t brightness_of(sample_t mean);
    logic [18:0] prod;
    logic [19:0] acc;
    logic [7:0]  quo;
    pct_t        res;
    prod = 19'(mean) * 19'd100;
    acc  = 20'(prod) + 20'(prod >> 12) + 20'd1;
    quo  = acc[19:12];
    if (mean >= FULL_SCALE) begin
      res = '0;
    end else if (mean <= DARK_LIMIT) begin
      res = PERCENT_MAX;
    end else begin
      res = PERCENT_MAX - quo[PCT_W-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hdl/light_level_moving_average_core.sv =====
// ----------------------------------------------------------------------------
// light_level_moving_average_core
// Boxcar average of the last 64 light-sensor samples with an inverted
// brightness percentage.
//
//   channel | dir | tdata fields (low bit up)
//   --------+-----+------------------------------------------------
//   s_axis  | in  | sample[11:0], zero[15:12]
//   m_axis  | out | mean_level[11:0], brightness_percent[18:12], zero
//
// One item per cycle sustained while m_tready stays high; an accepted item passes
// through the stage 1, stage 2 and output registers before m_tvalid rises.
// Stage 1 is the ring RAM read, stage 2 updates the running sum and mean,
// stage 3 scales the mean to percent into the output register.
// Reset clears sum, slot pointer and the per-entry valid bits at once.
// Back-pressure on m_tready stalls each stage only when the next one is full.
// ----------------------------------------------------------------------------
module light_level_moving_average_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [llma_pkg::IN_DATA_W-1:0]   s_tdata,   // sample[11:0]
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [llma_pkg::OUT_DATA_W-1:0]  m_tdata    // mean_level, brightness_percent
);

  logic                   in_acc;
  llma_pkg::slot_t        wr_slot;

  logic                   s1_valid;
  llma_pkg::slot_t        s1_slot;
  llma_pkg::sample_t      s1_sample;
  llma_pkg::sample_t      old_sample;
  logic                   s1_adv;

  llma_pkg::sum_t         window_sum;
  llma_pkg::sum_t         window_sum_next;

  logic                   s2_valid;
  llma_pkg::sample_t      s2_mean;
  logic                   s2_adv;
  logic                   s2_free;

  logic                   out_free;
  llma_pkg::sample_t      mean_level;
  llma_pkg::pct_t         brightness_percent;

  llma_pkg::ring_wr_t     ring_wr;

  assign out_free = !m_tvalid || m_tready;
  assign s2_adv   = s2_valid && out_free;
  assign s2_free  = !s2_valid || out_free;
  assign s1_adv   = s1_valid && s2_free;
  assign s_tready = !s1_valid || s2_free;
  assign in_acc   = s_tvalid && s_tready;

  assign ring_wr.en   = s1_adv;
  assign ring_wr.slot = s1_slot;
  assign ring_wr.data = s1_sample;

  llma_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_acc),
    .rd_slot (wr_slot),
    .rd_data (old_sample),
    .wr      (ring_wr)
  );

  assign window_sum_next = window_sum - llma_pkg::SUM_W'(old_sample)
                         + llma_pkg::SUM_W'(s1_sample);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_slot    <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      m_tvalid   <= 1'b0;
      window_sum <= '0;
    end else begin
      if (in_acc) begin
        wr_slot <= wr_slot + llma_pkg::slot_t'(1);
      end
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (s2_free) begin
        s2_valid <= s1_valid;
      end
      if (out_free) begin
        m_tvalid <= s2_valid;
      end
      if (s1_adv) begin
        window_sum <= window_sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_slot   <= wr_slot;
      s1_sample <= s_tdata[llma_pkg::SAMPLE_W-1:0];
    end
    if (s1_adv) begin
      s2_mean <= window_sum_next[llma_pkg::SUM_W-1 -: llma_pkg::SAMPLE_W];
    end
    if (s2_adv) begin
      mean_level         <= s2_mean;
      brightness_percent <= llma_pkg::brightness_of(s2_mean);
    end
  end

  assign m_tdata = {
    (llma_pkg::OUT_DATA_W - llma_pkg::SAMPLE_W - llma_pkg::PCT_W)'(0),
    brightness_percent,
    mean_level
  };

endmodule

// ===== hdl/llma_ring.sv =====
// ----------------------------------------------------------------------------
// llma_ring
// Sample ring: one synchronous RAM with registered read and a valid bit per
// entry, so entries not yet written read as zero after reset.
// ----------------------------------------------------------------------------
module llma_ring (
  input  logic               clk,
  input  logic               rst,
  input  logic               rd_en,
  input  llma_pkg::slot_t    rd_slot,
  output llma_pkg::sample_t  rd_data,
  input  llma_pkg::ring_wr_t wr
);

  llma_pkg::sample_t                 ring [llma_pkg::WINDOW];
  logic [llma_pkg::WINDOW-1:0]       written;
  llma_pkg::sample_t                 rd_word;
  logic                              rd_hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      ring[wr.slot] <= wr.data;
    end
    if (rd_en) begin
      rd_word <= ring[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_hit  <= 1'b0;
    end else begin
      if (wr.en) begin
        written[wr.slot] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit <= written[rd_slot];
      end
    end
  end

  assign rd_data = rd_hit ? rd_word : '0;

endmodule

// ===== hdl/llma_checker.sv =====
// ----------------------------------------------------------------------------
// llma_checker
// Port-level checks for the light-level moving average core.
// ----------------------------------------------------------------------------
module llma_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [llma_pkg::OUT_DATA_W-1:0]  m_tdata
);

  logic [llma_pkg::SAMPLE_W-1:0] mean_level;
  logic [llma_pkg::PCT_W-1:0]    brightness_percent;

  assign mean_level         = m_tdata[11:0];
  assign brightness_percent = m_tdata[18:12];

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("m_tvalid dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("m_tdata changed while stalled");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> brightness_percent <= llma_pkg::PERCENT_MAX)
    else $error("brightness above 100");

  a_dark_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && mean_level <= llma_pkg::DARK_LIMIT |->
      brightness_percent == llma_pkg::PERCENT_MAX)
    else $error("low mean not mapped to 100");

  a_first_out: assert property (@(posedge clk)
    $fell(rst) |-> !m_tvalid && s_tready)
    else $error("output valid or input blocked straight out of reset");

endmodule

bind light_level_moving_average_core llma_checker u_llma_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
